// ===== src/cdq_pkg.sv =====
// cdq_pkg: shared types and constants for the circular_deque block.
// Opcodes, status codes, cell command struct and data word type.
// No dependencies; compiled first.
`default_nettype none

package cdq_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 4;
    localparam int unsigned DEPTH_DEFAULT = 8;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t NO_DATA = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // What every cell of a chain does at a clock edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_BACK,  // take left neighbour, cell 0 takes the new word
        CELL_SHIFT_FWD,   // take right neighbour
        CELL_APPEND       // only the cell at the fill level takes the new word
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        word_t    word;
    } chain_cmd_t;

endpackage : cdq_pkg

`default_nettype wire

// ===== src/cdq_if.sv =====
// cdq_if: valid/ready channel interfaces for the circular_deque block.
// Request channel (opcode, value) and response channel (data, status, flags).
// Depends on cdq_pkg.
`default_nettype none

interface cdq_req_if;
    logic                                valid;
    logic                                ready;
    logic [cdq_pkg::OPCODE_W-1:0]        opcode;
    logic signed [cdq_pkg::WORD_W-1:0]   value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface : cdq_req_if

interface cdq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [cdq_pkg::WORD_W-1:0]   data;
    logic [cdq_pkg::STATUS_W-1:0]        status;
    logic [cdq_pkg::OCC_W-1:0]           occupancy;
    logic                                is_empty;
    logic                                is_full;

    modport source (output valid, output data, output status, output occupancy,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input data, input status, input occupancy,
                    input is_empty, input is_full, output ready);
endinterface : cdq_rsp_if

`default_nettype wire

// ===== src/cdq_cell.sv =====
// cdq_cell: one word slot of a deque chain.
// Shifts with its neighbours or takes the new word when it sits at the fill level.
// Depends on cdq_pkg.
`default_nettype none

module cdq_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 4
) (
    input  wire logic               clk,
    input  wire cdq_pkg::chain_cmd_t cmd,
    input  wire logic [CW-1:0]      count,
    input  wire cdq_pkg::word_t     left_word,
    input  wire cdq_pkg::word_t     right_word,
    output cdq_pkg::word_t          word
);

    cdq_pkg::word_t word_reg;
    cdq_pkg::word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        unique case (cmd.op)
            cdq_pkg::CELL_HOLD:       word_next = word_reg;
            cdq_pkg::CELL_SHIFT_BACK: word_next = left_word;
            cdq_pkg::CELL_SHIFT_FWD:  word_next = right_word;
            cdq_pkg::CELL_APPEND:
            begin
                if (count == CW'(IDX))
                begin
                    word_next = cmd.word;
                end
            end
            default:                  word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule : cdq_cell

`default_nettype wire

// ===== src/cdq_chain.sv =====
// cdq_chain: a row of DEPTH cdq_cell slots; slot 0 is the end the chain serves.
// Words enter at slot 0 (shift back) or at the fill level (append).
// Depends on cdq_pkg and cdq_cell.
`default_nettype none

module cdq_chain #(
    parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                clk,
    input  wire cdq_pkg::chain_cmd_t cmd,
    input  wire logic [CW-1:0]       count,
    output cdq_pkg::word_t           head
);

    cdq_pkg::word_t words [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cdq_pkg::word_t left_w;
        cdq_pkg::word_t right_w;

        if (i == 0)
        begin : g_first
            assign left_w = cmd.word;
        end
        else
        begin : g_mid_l
            assign left_w = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = words[i];
        end
        else
        begin : g_mid_r
            assign right_w = words[i+1];
        end

        cdq_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[i])
        );
    end

    assign head = words[0];

endmodule : cdq_chain

`default_nettype wire

// ===== src/circular_deque.sv =====
// circular_deque: double-ended queue of signed 32-bit words, top level.
// Two cell chains (front-ordered and rear-ordered) plus a fill counter.
// Depends on cdq_pkg, cdq_if, cdq_chain, cdq_cell.
//
// Usage:
//   req channel carries opcode and value; rsp channel returns one beat per
//   request with data, status, occupancy, is_empty and is_full.
//   Opcodes: push front, push rear, pop front, pop rear, peek front, peek rear.
//   A push on a full deque answers status full; a pop or peek on an empty one
//   answers status empty with data all ones (-1). Unused opcodes answer done, -1.
//   Latency: the response beat is valid the cycle after the request beat.
//   Throughput: one request per cycle unless a response stalls. Both ends are served
//   from slot 0 of their own chain; each cell does at most one shift or append.
//   Stall: while a response waits unaccepted, req.ready is low; a request is
//   still taken in the cycle the waiting response is accepted.
//   Reset: asynchronous, active low; the deque comes up empty and no response
//   is pending. Stored words are not cleared.
`default_nettype none

module circular_deque #(
    parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cdq_req_if.sink   req,
    cdq_rsp_if.source rsp
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic rsp_valid_reg;
    cdq_pkg::word_t     data_reg,      data_next;
    cdq_pkg::status_t   status_reg,    status_next;
    logic [cdq_pkg::OCC_W-1:0] occ_reg, occ_next;
    logic empty_reg, empty_next;
    logic full_reg,  full_next;

    cdq_pkg::chain_cmd_t front_cmd;
    cdq_pkg::chain_cmd_t rear_cmd;
    cdq_pkg::word_t      front_word;
    cdq_pkg::word_t      rear_word;

    logic accept;
    logic is_full_now;
    logic is_empty_now;

    assign req.ready    = !rsp_valid_reg || rsp.ready;
    assign accept       = req.valid && req.ready;
    assign is_full_now  = (count_reg == CW'(DEPTH));
    assign is_empty_now = (count_reg == '0);

    // front chain holds front..rear, rear chain holds rear..front
    always_comb
    begin
        front_cmd.op   = cdq_pkg::CELL_HOLD;
        front_cmd.word = cdq_pkg::word_t'(req.value);
        rear_cmd.op    = cdq_pkg::CELL_HOLD;
        rear_cmd.word  = cdq_pkg::word_t'(req.value);
        count_next     = count_reg;
        data_next      = cdq_pkg::NO_DATA;
        status_next    = cdq_pkg::ST_DONE;

        if (accept)
        begin
            unique case (req.opcode)
                cdq_pkg::OP_PUSH_FRONT:
                begin
                    if (is_full_now)
                    begin
                        status_next = cdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        front_cmd.op = cdq_pkg::CELL_SHIFT_BACK;
                        rear_cmd.op  = cdq_pkg::CELL_APPEND;
                        count_next   = count_reg + CW'(1);
                    end
                end
                cdq_pkg::OP_PUSH_REAR:
                begin
                    if (is_full_now)
                    begin
                        status_next = cdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        front_cmd.op = cdq_pkg::CELL_APPEND;
                        rear_cmd.op  = cdq_pkg::CELL_SHIFT_BACK;
                        count_next   = count_reg + CW'(1);
                    end
                end
                cdq_pkg::OP_POP_FRONT:
                begin
                    if (is_empty_now)
                    begin
                        status_next = cdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        data_next    = front_word;
                        front_cmd.op = cdq_pkg::CELL_SHIFT_FWD;
                        count_next   = count_reg - CW'(1);
                    end
                end
                cdq_pkg::OP_POP_REAR:
                begin
                    if (is_empty_now)
                    begin
                        status_next = cdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        data_next   = rear_word;
                        rear_cmd.op = cdq_pkg::CELL_SHIFT_FWD;
                        count_next  = count_reg - CW'(1);
                    end
                end
                cdq_pkg::OP_PEEK_FRONT:
                begin
                    if (is_empty_now)
                        status_next = cdq_pkg::ST_EMPTY;
                    else
                        data_next = front_word;
                end
                cdq_pkg::OP_PEEK_REAR:
                begin
                    if (is_empty_now)
                        status_next = cdq_pkg::ST_EMPTY;
                    else
                        data_next = rear_word;
                end
                default:
                begin
                    status_next = cdq_pkg::ST_DONE;
                end
            endcase
        end
    end

    assign occ_next   = cdq_pkg::OCC_W'(count_next);
    assign empty_next = (count_next == '0);
    assign full_next  = (count_next == CW'(DEPTH));

    cdq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_front (
        .clk   (clk),
        .cmd   (front_cmd),
        .count (count_reg),
        .head  (front_word)
    );

    cdq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_rear (
        .clk   (clk),
        .cmd   (rear_cmd),
        .count (count_reg),
        .head  (rear_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
            occ_reg    <= occ_next;
            empty_reg  <= empty_next;
            full_reg   <= full_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.data      = $signed(data_reg);
    assign rsp.status    = status_reg;
    assign rsp.occupancy = occ_reg;
    assign rsp.is_empty  = empty_reg;
    assign rsp.is_full   = full_reg;

endmodule : circular_deque

`default_nettype wire

// ===== src/cdq_checker.sv =====
// cdq_checker: port-level assertions for circular_deque, bound to the top level.
// Watches the request and response channels only.
// Depends on cdq_pkg and circular_deque.
`default_nettype none

module cdq_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [cdq_pkg::WORD_W-1:0]    rsp_data,
    input wire logic [cdq_pkg::STATUS_W-1:0]  rsp_status,
    input wire logic [cdq_pkg::OCC_W-1:0]     rsp_occupancy,
    input wire logic                          rsp_is_empty,
    input wire logic                          rsp_is_full
);

    // every request beat gives a response beat in the next cycle
    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("request beat without response beat");

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)
            && $stable(rsp_status) && $stable(rsp_occupancy))
        else $error("stalled response beat changed");

    // refused for emptiness: no data and the deque is empty
    a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == cdq_pkg::ST_EMPTY |->
            rsp_data == cdq_pkg::NO_DATA && rsp_is_empty && rsp_occupancy == '0)
        else $error("empty refusal with inconsistent flags");

    // refused for fullness: no data, and the deque is full and not empty
    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == cdq_pkg::ST_FULL |->
            rsp_is_full && !rsp_is_empty && rsp_data == cdq_pkg::NO_DATA)
        else $error("full refusal with inconsistent flags");

    // empty and full flags never together, empty means zero occupancy
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_is_empty && rsp_is_full)
            && (!rsp_is_empty || rsp_occupancy == '0))
        else $error("occupancy flags inconsistent");

endmodule : cdq_checker

bind circular_deque cdq_checker u_cdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_data      (rsp.data),
    .rsp_status    (rsp.status),
    .rsp_occupancy (rsp.occupancy),
    .rsp_is_empty  (rsp.is_empty),
    .rsp_is_full   (rsp.is_full)
);

`default_nettype wire

// ===== verif/cdq_checker.sv =====
// cdq_tb_checker: watches the request and response channels of circular_deque,
// predicts each response beat and compares it field by field.
// Depends on cdq_pkg and cdq_if.
module cdq_tb_checker #(
    parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cdq_req_if        req,
    cdq_rsp_if        rsp,
    output int        outstanding,
    output int        fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        cdq_pkg::word_t            data;
        cdq_pkg::status_t          status;
        logic [cdq_pkg::OCC_W-1:0] occupancy;
        logic                      is_empty;
        logic                      is_full;
    } deque_result_t;

    cdq_pkg::word_t ring[DEPTH];
    int unsigned    head_slot;
    int unsigned    tail_slot;
    bit             holds_any;
    deque_result_t  awaited[$];
    deque_result_t  want;
    int             mismatches;

    function automatic bit ring_full();
        return holds_any && ((tail_slot + 1) % DEPTH == head_slot);
    endfunction

    function automatic logic [cdq_pkg::OCC_W-1:0] fill_level();
        if (!holds_any)
            return '0;
        return cdq_pkg::OCC_W'(((tail_slot + DEPTH - head_slot) % DEPTH) + 1);
    endfunction

    // Applies one operation to the shadow ring and returns the response it gives
    function automatic deque_result_t apply_deque_op(logic [cdq_pkg::OPCODE_W-1:0] op,
                                                     cdq_pkg::word_t val);
        deque_result_t r;
        bit            at_front;
        r.data   = cdq_pkg::NO_DATA;
        r.status = cdq_pkg::ST_DONE;
        case (op)
            cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR:
            begin
                if (ring_full())
                begin
                    r.status = cdq_pkg::ST_FULL;
                end
                else if (!holds_any)
                begin
                    // first word lands in slot 0 whichever end is named
                    head_slot = 0;
                    tail_slot = 0;
                    holds_any = 1'b1;
                    ring[0]   = val;
                end
                else if (op == cdq_pkg::OP_PUSH_FRONT)
                begin
                    head_slot       = (head_slot + DEPTH - 1) % DEPTH;
                    ring[head_slot] = val;
                end
                else
                begin
                    tail_slot       = (tail_slot + 1) % DEPTH;
                    ring[tail_slot] = val;
                end
            end
            cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR,
            cdq_pkg::OP_PEEK_FRONT, cdq_pkg::OP_PEEK_REAR:
            begin
                if (!holds_any)
                begin
                    r.status = cdq_pkg::ST_EMPTY;
                end
                else
                begin
                    at_front = (op == cdq_pkg::OP_POP_FRONT) || (op == cdq_pkg::OP_PEEK_FRONT);
                    r.data   = ring[at_front ? head_slot : tail_slot];
                    if (op == cdq_pkg::OP_POP_FRONT || op == cdq_pkg::OP_POP_REAR)
                    begin
                        if (head_slot == tail_slot)
                        begin
                            holds_any = 1'b0;
                            head_slot = 0;
                            tail_slot = 0;
                        end
                        else if (at_front)
                            head_slot = (head_slot + 1) % DEPTH;
                        else
                            tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
                    end
                end
            end
            default: ;  // spare opcodes: no change, done, all ones
        endcase
        r.occupancy = fill_level();
        r.is_empty  = !holds_any;
        r.is_full   = ring_full();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holds_any   = 1'b0;
            head_slot   = 0;
            tail_slot   = 0;
            mismatches  = 0;
            awaited.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            // response beats always belong to earlier requests: compare first
            if (rsp.valid && rsp.ready)
            begin
                if (awaited.size() == 0)
                begin
                    $error("response beat with nothing awaited");
                    mismatches++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (rsp.data !== want.data)
                    begin
                        $error("data: expected %0d, got %0d", $signed(want.data), rsp.data);
                        mismatches++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy,
                               rsp.occupancy);
                        mismatches++;
                    end
                    if (rsp.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0b, got %0b", want.is_empty, rsp.is_empty);
                        mismatches++;
                    end
                    if (rsp.is_full !== want.is_full)
                    begin
                        $error("is_full: expected %0b, got %0b", want.is_full, rsp.is_full);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
                awaited.push_back(apply_deque_op(req.opcode, req.value));
            outstanding <= awaited.size();
            fail_count  <= mismatches;
        end
    end

endmodule : cdq_tb_checker

// ===== verif/tb_circular_deque.sv =====
// tb_circular_deque: clock, reset and stimulus for circular_deque, with a
// random receiver; prediction and checking sit in cdq_tb_checker.
// Depends on cdq_pkg, cdq_if, circular_deque and cdq_tb_checker.
module tb_circular_deque;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH           = cdq_pkg::DEPTH_DEFAULT;
    localparam int unsigned RANDOM_ITEMS    = 480;
    localparam int unsigned HOLD_OFF_CYCLES = 60;
    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned SETTLE_CYCLES   = 8;

    // opcodes with no operation behind them
    localparam logic [cdq_pkg::OPCODE_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [cdq_pkg::OPCODE_W-1:0] OP_SPARE_B = 3'd7;

    localparam cdq_pkg::word_t WORD_MAX  = 32'h7FFF_FFFF;
    localparam cdq_pkg::word_t WORD_MIN  = 32'h8000_0000;
    localparam cdq_pkg::word_t WORD_ZERO = 32'h0000_0000;
    localparam cdq_pkg::word_t WORD_ODD  = 32'hAAAA_AAAA;
    localparam cdq_pkg::word_t WORD_EVEN = 32'h5555_5555;

    logic clk;
    logic rst_n;
    int   outstanding;
    int   fail_count;

    int unsigned burst_left;
    int unsigned idle_cycles;
    bit          hold_off_asked;
    bit          hold_off_done;
    bit          steady_sender;

    cdq_req_if req_ch ();
    cdq_rsp_if rsp_ch ();

    circular_deque #(.DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cdq_tb_checker #(.DEPTH(DEPTH)) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offers one request beat and returns at the edge that takes it
    task automatic offer_beat(input logic [cdq_pkg::OPCODE_W-1:0] op,
                              input cdq_pkg::word_t val);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0 && !steady_sender)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.value  <= val;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        logic [cdq_pkg::OPCODE_W-1:0] op;
        cdq_pkg::word_t               val;
        int unsigned                  mood;
        int unsigned                  draw;
        int unsigned                  push_pct;
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.opcode  <= cdq_pkg::OP_PUSH_FRONT;
        req_ch.value   <= WORD_ZERO;
        burst_left     = 0;
        hold_off_asked = 1'b0;
        steady_sender  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque: every read is refused, spare opcodes do nothing
        offer_beat(cdq_pkg::OP_POP_FRONT, WORD_MAX);
        offer_beat(cdq_pkg::OP_POP_REAR, WORD_MIN);
        offer_beat(cdq_pkg::OP_PEEK_FRONT, WORD_ZERO);
        offer_beat(cdq_pkg::OP_PEEK_REAR, cdq_pkg::NO_DATA);
        offer_beat(OP_SPARE_A, WORD_ODD);
        offer_beat(OP_SPARE_B, WORD_EVEN);
        // first push from either end, then pop of the last word
        offer_beat(cdq_pkg::OP_PUSH_FRONT, WORD_MAX);
        offer_beat(cdq_pkg::OP_POP_REAR, WORD_ZERO);
        offer_beat(cdq_pkg::OP_PUSH_REAR, WORD_MIN);
        offer_beat(cdq_pkg::OP_PEEK_FRONT, WORD_ZERO);
        offer_beat(cdq_pkg::OP_PEEK_REAR, WORD_ZERO);
        // fill to the brim from both ends, then push into a full deque
        offer_beat(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::NO_DATA);
        offer_beat(cdq_pkg::OP_PUSH_REAR, WORD_ZERO);
        offer_beat(cdq_pkg::OP_PUSH_FRONT, 32'd1);
        offer_beat(cdq_pkg::OP_PUSH_REAR, WORD_ODD);
        offer_beat(cdq_pkg::OP_PUSH_FRONT, WORD_EVEN);
        offer_beat(cdq_pkg::OP_PUSH_REAR, WORD_MIN);
        offer_beat(cdq_pkg::OP_PUSH_FRONT, WORD_MAX);
        offer_beat(cdq_pkg::OP_PUSH_REAR, WORD_ODD);
        offer_beat(cdq_pkg::OP_PUSH_FRONT, WORD_EVEN);
        offer_beat(cdq_pkg::OP_PEEK_FRONT, WORD_ZERO);
        offer_beat(cdq_pkg::OP_PEEK_REAR, WORD_ZERO);
        offer_beat(cdq_pkg::OP_POP_FRONT, WORD_ZERO);
        offer_beat(cdq_pkg::OP_POP_REAR, WORD_ZERO);
        wait_drained();

        mood = 2;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                mood = $urandom_range(0, 2);
            if (n == 120)
            begin
                // receiver goes quiet while requests keep coming
                hold_off_asked = 1'b1;
                burst_left     = 40;
            end
            if (n == 260)
                wait_drained();
            steady_sender = (n >= 380 && n < 430);

            push_pct = (mood == 0) ? 70 : (mood == 1) ? 25 : 45;
            draw = $urandom_range(0, 99);
            if (draw < 4)
                op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            else if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_REAR;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       op = cdq_pkg::OP_POP_FRONT;
                    1:       op = cdq_pkg::OP_POP_REAR;
                    2:       op = cdq_pkg::OP_PEEK_FRONT;
                    default: op = cdq_pkg::OP_PEEK_REAR;
                endcase
            end

            case ($urandom_range(0, 15))
                0:       val = WORD_MAX;
                1:       val = WORD_MIN;
                2:       val = cdq_pkg::NO_DATA;
                3:       val = WORD_ZERO;
                default: val = $urandom;
            endcase
            offer_beat(op, val);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_circular_deque: PASS");
        else
            $display("tb_circular_deque: FAIL");
        $finish;
    end

    // Receiver: segments of steady, random and periodic back-pressure
    initial
    begin
        int unsigned seg_len;
        int unsigned seg_mode;
        logic        take;
        rsp_ch.ready <= 1'b0;
        hold_off_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            seg_len  = $urandom_range(10, 60);
            seg_mode = $urandom_range(0, 2);
            for (int unsigned tick = 0; tick < seg_len; tick++)
            begin
                if (hold_off_asked && !hold_off_done)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    hold_off_done = 1'b1;
                end
                case (seg_mode)
                    0:       take = 1'b1;
                    1:       take = ($urandom_range(0, 99) >= 35);
                    default: take = ((tick % 3) != 2);
                endcase
                rsp_ch.ready <= take;
                @(posedge clk);
            end
        end
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_circular_deque: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule : tb_circular_deque

// ===== sim.f =====
src/cdq_pkg.sv
src/cdq_if.sv
src/cdq_cell.sv
src/cdq_chain.sv
src/circular_deque.sv
src/cdq_checker.sv
verif/cdq_checker.sv
verif/tb_circular_deque.sv
